// ----- sv/mdfs_pkg.sv -----
package mdfs_pkg;

  // Coordinate width: covers 0..511; the 7-bit sizes and coordinates allow grids up to 127 on a side.
  localparam int unsigned CRD_W = 9;
  localparam int unsigned LEN_W = 13;
  localparam int unsigned IDX_W = 12;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 7;

  typedef enum logic [1:0] {
    OP_BLOCK = 2'd0,
    OP_SOLVE = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_WALLED     = 3'd0,
    ST_START_REF  = 3'd1,
    ST_GOAL_REF   = 3'd2,
    ST_OUT_RANGE  = 3'd3,
    ST_FOUND      = 3'd4,
    ST_NO_PATH    = 3'd5,
    ST_ENTRY      = 3'd6,
    ST_BAD_INDEX  = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_UP    = 2'd3
  } dir_e;

  localparam logic [CFG_IDX_W-1:0] CFG_MAZE_ROWS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAZE_COLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_ROW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_COL  = 3'd5;

  typedef struct packed {
    op_e         op;
    logic [6:0]  cell_row;
    logic [6:0]  cell_col;
    logic [11:0] path_index;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [12:0] path_length;
    logic [6:0]  out_row;
    logic [6:0]  out_col;
    logic        is_last;
  } out_item_t;

  typedef struct packed {
    logic wall_we;
    logic wall_val;
    logic seen_we;
    logic seen_val;
  } mark_wr_t;

  typedef struct packed {
    logic wall;
    logic seen;
  } mark_rd_t;

endpackage

// ----- sv/mdfs_mark_mem.sv -----
module mdfs_mark_mem #(
  parameter int unsigned AW = 12
) (
  input  logic              clk_i,
  input  mdfs_pkg::mark_wr_t wr_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [AW-1:0]     raddr_i,
  output mdfs_pkg::mark_rd_t rd_o
);
  import mdfs_pkg::*;

  logic wall_q [2**AW];
  logic seen_q [2**AW];
  mark_rd_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.wall_we) begin
      wall_q[waddr_i] <= wr_i.wall_val;
    end
    if (wr_i.seen_we) begin
      seen_q[waddr_i] <= wr_i.seen_val;
    end
    rd_q.wall <= wall_q[raddr_i];
    rd_q.seen <= seen_q[raddr_i];
  end

  assign rd_o = rd_q;

endmodule

// ----- sv/mdfs_stack_mem.sv -----
module mdfs_stack_mem #(
  parameter int unsigned AW = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [AW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [AW-1:0] rdata_o
);

  logic [AW-1:0] mem_q [2**AW];
  logic [AW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/mdfs_nbr.sv -----
module mdfs_nbr #(
  parameter int unsigned RW = 6,
  parameter int unsigned CW = 6
) (
  input  logic [RW-1:0]              cur_row_i,
  input  logic [CW-1:0]              cur_col_i,
  input  mdfs_pkg::dir_e             dir_i,
  input  logic [mdfs_pkg::CRD_W-1:0] rows_i,
  input  logic [mdfs_pkg::CRD_W-1:0] cols_i,
  output logic                       ok_o,
  output logic [RW-1:0]              row_o,
  output logic [CW-1:0]              col_o
);
  import mdfs_pkg::*;

  logic [CRD_W-1:0] r9, c9, nxt_r, nxt_c;

  assign r9 = CRD_W'(cur_row_i);
  assign c9 = CRD_W'(cur_col_i);

  // One add or subtract and one bound compare per probe.
  always_comb begin
    nxt_r = r9;
    nxt_c = c9;
    ok_o  = 1'b0;
    case (dir_i)
      DIR_RIGHT: begin
        nxt_c = c9 + CRD_W'(1);
        ok_o  = nxt_c < cols_i;
      end
      DIR_DOWN: begin
        nxt_r = r9 + CRD_W'(1);
        ok_o  = nxt_r < rows_i;
      end
      DIR_LEFT: begin
        nxt_c = c9 - CRD_W'(1);
        ok_o  = c9 != '0;
      end
      DIR_UP: begin
        nxt_r = r9 - CRD_W'(1);
        ok_o  = r9 != '0;
      end
      default: begin
        ok_o = 1'b0;
      end
    endcase
  end

  assign row_o = nxt_r[RW-1:0];
  assign col_o = nxt_c[CW-1:0];

endmodule

// ----- sv/maze_dfs_path_finder.sv -----
// Channel  Dir  Handshake            Beat
// in       in   in_valid_i/in_stall_o   in_item_i  (op, cell_row, cell_col, path_index)
// out      out  out_valid_o/out_stall_i out_item_o (status, path_length, out_row, ...)
// cfg      in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Block, clear, rejected read: result registered in the cycle after the beat; a valid
// read passes S_RD first (registered stack read). Solve: visited-mark pass over all
// 2**(RW+CW) cells (4096 at 64x64), start push, then per step a goal check, a probe
// and mark check per in-range neighbor (just the probe one past the border) and a
// stack read per backtrack. Reset and clear run a clearing pass over all cells with
// input stalled; config writes are taken. A stalled output holds the next input off.
module maze_dfs_path_finder #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  mdfs_pkg::in_item_t                   in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output mdfs_pkg::out_item_t                  out_item_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [mdfs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mdfs_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import mdfs_pkg::*;

  localparam int unsigned RW = $clog2(MAX_ROWS);
  localparam int unsigned CW = $clog2(MAX_COLS);
  localparam int unsigned AW = RW + CW;
  localparam int unsigned DW = AW + 1;
  localparam int unsigned CMP_W = (DW > LEN_W) ? DW : LEN_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SWEEP = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_TOP   = 3'd3;
  localparam logic [2:0] S_PROBE = 3'd4;
  localparam logic [2:0] S_CHK   = 3'd5;
  localparam logic [2:0] S_POPW  = 3'd6;
  localparam logic [2:0] S_RD    = 3'd7;

  function automatic logic [CRD_W-1:0] clampv(logic [6:0] v, logic [CRD_W-1:0] hi);
    logic [CRD_W-1:0] w;
    w = CRD_W'(v);
    if (w == '0) begin
      return CRD_W'(1);
    end
    if (w > hi) begin
      return hi;
    end
    return w;
  endfunction

  // config registers
  logic [6:0] rows_q, cols_q, srow_q, scol_q, grow_q, gcol_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 7'd8;
      cols_q <= 7'd8;
      srow_q <= 7'd1;
      scol_q <= 7'd1;
      grow_q <= 7'd8;
      gcol_q <= 7'd8;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MAZE_ROWS: rows_q <= cfg_data_i;
        CFG_MAZE_COLS: cols_q <= cfg_data_i;
        CFG_START_ROW: srow_q <= cfg_data_i;
        CFG_START_COL: scol_q <= cfg_data_i;
        CFG_GOAL_ROW:  grow_q <= cfg_data_i;
        CFG_GOAL_COL:  gcol_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [CRD_W-1:0] nr, nc, sr, sc, gr, gc;
  logic [CRD_W-1:0] sr_m1, sc_m1, gr_m1, gc_m1;
  logic [RW-1:0]    s_row0, g_row0;
  logic [CW-1:0]    s_col0, g_col0;

  assign nr = clampv(rows_q, CRD_W'(MAX_ROWS));
  assign nc = clampv(cols_q, CRD_W'(MAX_COLS));
  assign sr = clampv(srow_q, nr);
  assign sc = clampv(scol_q, nc);
  assign gr = clampv(grow_q, nr);
  assign gc = clampv(gcol_q, nc);
  assign sr_m1 = sr - CRD_W'(1);
  assign sc_m1 = sc - CRD_W'(1);
  assign gr_m1 = gr - CRD_W'(1);
  assign gc_m1 = gc - CRD_W'(1);
  assign s_row0 = sr_m1[RW-1:0];
  assign s_col0 = sc_m1[CW-1:0];
  assign g_row0 = gr_m1[RW-1:0];
  assign g_col0 = gc_m1[CW-1:0];

  // sequencer state
  logic [2:0]    state_q, state_d;
  logic          sweep_full_q, sweep_full_d;
  logic [AW-1:0] sweep_addr_q, sweep_addr_d;
  logic [DW-1:0] depth_q, depth_d;
  logic          found_q, found_d;
  logic [RW-1:0] cur_row_q, cur_row_d;
  logic [CW-1:0] cur_col_q, cur_col_d;
  dir_e          dir_q, dir_d;
  logic          last_q, last_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_q, out_d;

  // memories and neighbor unit
  mark_wr_t      mark_wr;
  logic [AW-1:0] mark_waddr;
  mark_rd_t      mark_rd;
  logic          stk_we;
  logic [AW-1:0] stk_waddr, stk_wdata, stk_raddr, stk_rdata;
  logic          nb_ok, nb_is_goal;
  logic [RW-1:0] nb_row;
  logic [CW-1:0] nb_col;

  mdfs_nbr #(.RW(RW), .CW(CW)) u_nbr (
    .cur_row_i (cur_row_q),
    .cur_col_i (cur_col_q),
    .dir_i     (dir_q),
    .rows_i    (nr),
    .cols_i    (nc),
    .ok_o      (nb_ok),
    .row_o     (nb_row),
    .col_o     (nb_col)
  );

  assign nb_is_goal = (nb_row == g_row0) && (nb_col == g_col0);

  mdfs_mark_mem #(.AW(AW)) u_marks (
    .clk_i   (clk_i),
    .wr_i    (mark_wr),
    .waddr_i (mark_waddr),
    .raddr_i ({nb_row, nb_col}),
    .rd_o    (mark_rd)
  );

  mdfs_stack_mem #(.AW(AW)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // input decode
  logic             in_accept;
  logic [CRD_W-1:0] cr9, cc9, cr_m1, cc_m1;
  logic [CMP_W-1:0] pi_ext, depth_ext, pi_p1;
  logic [LEN_W-1:0] path_len;
  logic [DW-1:0]    pop_idx;
  logic [CRD_W-1:0] rd_row, rd_col;
  logic             give_up;

  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign cr9   = CRD_W'(in_item_i.cell_row);
  assign cc9   = CRD_W'(in_item_i.cell_col);
  assign cr_m1 = cr9 - CRD_W'(1);
  assign cc_m1 = cc9 - CRD_W'(1);

  assign pi_ext    = CMP_W'(in_item_i.path_index);
  assign depth_ext = CMP_W'(depth_q);
  assign pi_p1     = pi_ext + CMP_W'(1);
  assign path_len  = found_q ? depth_ext[LEN_W-1:0] : '0;
  assign pop_idx   = depth_q - DW'(2);
  assign stk_raddr = (state_q == S_IDLE) ? pi_ext[AW-1:0] : pop_idx[AW-1:0];
  assign rd_row    = CRD_W'(stk_rdata[AW-1:CW]) + CRD_W'(1);
  assign rd_col    = CRD_W'(stk_rdata[CW-1:0]) + CRD_W'(1);

  always_comb begin
    state_d      = state_q;
    sweep_full_d = sweep_full_q;
    sweep_addr_d = sweep_addr_q;
    depth_d      = depth_q;
    found_d      = found_q;
    cur_row_d    = cur_row_q;
    cur_col_d    = cur_col_q;
    dir_d        = dir_q;
    last_d       = last_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    mark_wr      = '0;
    mark_waddr   = {nb_row, nb_col};
    stk_we       = 1'b0;
    stk_waddr    = depth_q[AW-1:0];
    stk_wdata    = {nb_row, nb_col};
    give_up      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          case (in_item_i.op)
            OP_BLOCK: begin
              out_valid_d = 1'b1;
              out_d       = '0;
              out_d.path_length = path_len;
              if (cr9 == sr && cc9 == sc) begin
                out_d.status = ST_START_REF;
              end else if (cr9 == gr && cc9 == gc) begin
                out_d.status = ST_GOAL_REF;
              end else if (cr9 == '0 || cr9 > nr || cc9 == '0 || cc9 > nc) begin
                out_d.status = ST_OUT_RANGE;
              end else begin
                out_d.status     = ST_WALLED;
                mark_wr.wall_we  = 1'b1;
                mark_wr.wall_val = 1'b1;
                mark_waddr       = {cr_m1[RW-1:0], cc_m1[CW-1:0]};
              end
            end
            OP_SOLVE: begin
              state_d      = S_SWEEP;
              sweep_full_d = 1'b0;
              sweep_addr_d = '0;
              found_d      = 1'b0;
              depth_d      = '0;
            end
            OP_READ: begin
              if (found_q && pi_ext < depth_ext) begin
                state_d = S_RD;
                last_d  = pi_p1 == depth_ext;
              end else begin
                out_valid_d       = 1'b1;
                out_d             = '0;
                out_d.status      = ST_BAD_INDEX;
                out_d.path_length = path_len;
              end
            end
            OP_CLEAR: begin
              state_d      = S_SWEEP;
              sweep_full_d = 1'b1;
              sweep_addr_d = '0;
              found_d      = 1'b0;
              depth_d      = '0;
              out_valid_d  = 1'b1;
              out_d        = '0;
              out_d.status = ST_WALLED;
            end
            default: ;
          endcase
        end
      end
      S_SWEEP: begin
        mark_wr.seen_we  = 1'b1;
        mark_wr.wall_we  = sweep_full_q;
        mark_waddr       = sweep_addr_q;
        sweep_addr_d     = sweep_addr_q + AW'(1);
        if (sweep_addr_q == '1) begin
          state_d = sweep_full_q ? S_IDLE : S_START;
        end
      end
      S_START: begin
        stk_we           = 1'b1;
        stk_waddr        = '0;
        stk_wdata        = {s_row0, s_col0};
        mark_wr.seen_we  = 1'b1;
        mark_wr.seen_val = 1'b1;
        mark_waddr       = {s_row0, s_col0};
        depth_d          = DW'(1);
        cur_row_d        = s_row0;
        cur_col_d        = s_col0;
        state_d          = S_TOP;
      end
      S_TOP: begin
        if (cur_row_q == g_row0 && cur_col_q == g_col0) begin
          found_d           = 1'b1;
          out_valid_d       = 1'b1;
          out_d             = '0;
          out_d.status      = ST_FOUND;
          out_d.path_length = depth_ext[LEN_W-1:0];
          state_d           = S_IDLE;
        end else begin
          dir_d   = DIR_RIGHT;
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (nb_ok) begin
          state_d = S_CHK;
        end else begin
          give_up = 1'b1;
        end
      end
      S_CHK: begin
        if (!mark_rd.seen && (nb_is_goal || !mark_rd.wall)) begin
          stk_we           = 1'b1;
          mark_wr.seen_we  = 1'b1;
          mark_wr.seen_val = 1'b1;
          depth_d          = depth_q + DW'(1);
          cur_row_d        = nb_row;
          cur_col_d        = nb_col;
          state_d          = S_TOP;
        end else begin
          give_up = 1'b1;
        end
      end
      S_POPW: begin
        cur_row_d = stk_rdata[AW-1:CW];
        cur_col_d = stk_rdata[CW-1:0];
        state_d   = S_TOP;
      end
      S_RD: begin
        out_valid_d       = 1'b1;
        out_d.status      = ST_ENTRY;
        out_d.path_length = path_len;
        out_d.out_row     = rd_row[6:0];
        out_d.out_col     = rd_col[6:0];
        out_d.is_last     = last_q;
        state_d           = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // direction exhausted or neighbor not free
    if (give_up) begin
      if (dir_q == DIR_UP) begin
        depth_d = depth_q - DW'(1);
        if (depth_q == DW'(1)) begin
          out_valid_d  = 1'b1;
          out_d        = '0;
          out_d.status = ST_NO_PATH;
          state_d      = S_IDLE;
        end else begin
          state_d = S_POPW;
        end
      end else begin
        dir_d   = dir_e'(dir_q + 2'd1);
        state_d = S_PROBE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_SWEEP;
      sweep_full_q <= 1'b1;
      sweep_addr_q <= '0;
      depth_q      <= '0;
      found_q      <= 1'b0;
      dir_q        <= DIR_RIGHT;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      sweep_full_q <= sweep_full_d;
      sweep_addr_q <= sweep_addr_d;
      depth_q      <= depth_d;
      found_q      <= found_d;
      dir_q        <= dir_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_row_q <= cur_row_d;
    cur_col_q <= cur_col_d;
    last_q    <= last_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_found_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> depth_q != '0)
    else $error("path marked found with empty stack");

  a_chk_after_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CHK |-> $past(state_q) == S_PROBE)
    else $error("mark check without probe");

  a_walk_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TOP || state_q == S_PROBE || state_q == S_POPW) |-> depth_q != '0)
    else $error("search step with empty stack");

  a_out_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD || state_q == S_TOP) |-> !out_valid_q)
    else $error("result would overwrite pending beat");

endmodule

// ----- tb/maze_dfs_checker.sv -----
`timescale 1ns / 100ps

module maze_dfs_checker #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  mdfs_pkg::in_item_t                  in_item_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  mdfs_pkg::out_item_t                 out_item_i,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [mdfs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mdfs_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output int unsigned                         fail_cnt_o,
  output int unsigned                         pending_o,
  output int unsigned                         checked_o
);
  import mdfs_pkg::*;

  localparam int unsigned CELLS = MAX_ROWS * MAX_COLS;
  localparam int unsigned CELL_W = $clog2(CELLS);
  localparam int unsigned CFG_REG_CNT = 6;

  // marks[k][0] wall, marks[k][1] visited
  logic [1:0]            marks [CELLS];
  logic [CELL_W-1:0]     trail [CELLS];
  int unsigned           trail_len;
  bit                    route_ok;
  logic [CFG_DATA_W-1:0] maze_cfg [CFG_REG_CNT];
  out_item_t             due_results [$];
  out_item_t             want;
  int unsigned           n_fail;
  int unsigned           n_checked;

  function automatic int clamp_to(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void model_reset();
    int unsigned k;
    for (k = 0; k < CELLS; k++) marks[k] = 2'b00;
    trail_len = 0;
    route_ok = 1'b0;
    maze_cfg[CFG_MAZE_ROWS] = 7'd8;
    maze_cfg[CFG_MAZE_COLS] = 7'd8;
    maze_cfg[CFG_START_ROW] = 7'd1;
    maze_cfg[CFG_START_COL] = 7'd1;
    maze_cfg[CFG_GOAL_ROW]  = 7'd8;
    maze_cfg[CFG_GOAL_COL]  = 7'd8;
    due_results.delete();
  endfunction

  function automatic bit is_open(int r, int c, int nr, int nc, int gr, int gc);
    logic [1:0] m;
    if (r < 1 || r > nr || c < 1 || c > nc) return 1'b0;
    m = marks[(r - 1) * MAX_COLS + c - 1];
    if (m[1]) return 1'b0;
    if (r == gr && c == gc) return 1'b1;
    return !m[0];
  endfunction

  function automatic void enter_cell(int r, int c);
    int unsigned k;
    k = (r - 1) * MAX_COLS + c - 1;
    marks[k][1] = 1'b1;
    if (trail_len < CELLS) begin
      trail[trail_len] = CELL_W'(k);
      trail_len++;
    end
  endfunction

  function automatic void run_search();
    int nr, nc, sr, sc, gr, gc, r, c, tr, tc, di;
    int unsigned k;
    bit moved;
    nr = clamp_to(maze_cfg[CFG_MAZE_ROWS], MAX_ROWS);
    nc = clamp_to(maze_cfg[CFG_MAZE_COLS], MAX_COLS);
    sr = clamp_to(maze_cfg[CFG_START_ROW], nr);
    sc = clamp_to(maze_cfg[CFG_START_COL], nc);
    gr = clamp_to(maze_cfg[CFG_GOAL_ROW], nr);
    gc = clamp_to(maze_cfg[CFG_GOAL_COL], nc);
    for (k = 0; k < CELLS; k++) marks[k][1] = 1'b0;
    trail_len = 0;
    route_ok = 1'b0;
    enter_cell(sr, sc);
    while (trail_len > 0) begin
      r = int'(trail[trail_len - 1]) / MAX_COLS + 1;
      c = int'(trail[trail_len - 1]) % MAX_COLS + 1;
      if (r == gr && c == gc) begin
        route_ok = 1'b1;
        return;
      end
      moved = 1'b0;
      for (di = 0; di < 4 && !moved; di++) begin
        case (dir_e'(di))
          DIR_RIGHT: begin tr = r;     tc = c + 1; end
          DIR_DOWN:  begin tr = r + 1; tc = c;     end
          DIR_LEFT:  begin tr = r;     tc = c - 1; end
          DIR_UP:    begin tr = r - 1; tc = c;     end
          default:   begin tr = 0;     tc = 0;     end
        endcase
        if (is_open(tr, tc, nr, nc, gr, gc)) begin
          enter_cell(tr, tc);
          moved = 1'b1;
        end
      end
      if (!moved) trail_len--;
    end
  endfunction

  function automatic out_item_t dfs_predict(in_item_t it);
    out_item_t res;
    int nr, nc, sr, sc, gr, gc;
    int unsigned k;
    res = '0;
    nr = clamp_to(maze_cfg[CFG_MAZE_ROWS], MAX_ROWS);
    nc = clamp_to(maze_cfg[CFG_MAZE_COLS], MAX_COLS);
    case (it.op)
      OP_BLOCK: begin
        sr = clamp_to(maze_cfg[CFG_START_ROW], nr);
        sc = clamp_to(maze_cfg[CFG_START_COL], nc);
        gr = clamp_to(maze_cfg[CFG_GOAL_ROW], nr);
        gc = clamp_to(maze_cfg[CFG_GOAL_COL], nc);
        if (int'(it.cell_row) == sr && int'(it.cell_col) == sc) begin
          res.status = ST_START_REF;
        end else if (int'(it.cell_row) == gr && int'(it.cell_col) == gc) begin
          res.status = ST_GOAL_REF;
        end else if (it.cell_row < 1 || int'(it.cell_row) > nr ||
                     it.cell_col < 1 || int'(it.cell_col) > nc) begin
          res.status = ST_OUT_RANGE;
        end else begin
          marks[(int'(it.cell_row) - 1) * MAX_COLS + int'(it.cell_col) - 1][0] = 1'b1;
          res.status = ST_WALLED;
        end
      end
      OP_SOLVE: begin
        run_search();
        res.status = route_ok ? ST_FOUND : ST_NO_PATH;
      end
      OP_READ: begin
        if (route_ok && it.path_index < trail_len) begin
          res.status = ST_ENTRY;
          res.out_row = 7'(int'(trail[it.path_index]) / MAX_COLS + 1);
          res.out_col = 7'(int'(trail[it.path_index]) % MAX_COLS + 1);
          res.is_last = (int'(it.path_index) + 1 == trail_len);
        end else begin
          res.status = ST_BAD_INDEX;
        end
      end
      OP_CLEAR: begin
        for (k = 0; k < CELLS; k++) marks[k] = 2'b00;
        trail_len = 0;
        route_ok = 1'b0;
        res.status = ST_WALLED;
      end
      default: ;
    endcase
    res.path_length = route_ok ? LEN_W'(trail_len) : '0;
    return res;
  endfunction

  task automatic report(string what, int unsigned got, int unsigned exp_val);
    if (n_fail < 40)
      $display("%0t: mismatch on %s, got %0d, want %0d", $time, what, got, exp_val);
    n_fail++;
  endtask

  initial begin
    n_fail = 0;
    n_checked = 0;
    model_reset();
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_reset();
    end else begin
      if (cfg_valid_i && cfg_ready_i && cfg_index_i < CFG_REG_CNT)
        maze_cfg[cfg_index_i] = cfg_data_i;
      if (in_valid_i && !in_stall_i)
        due_results.push_back(dfs_predict(in_item_i));
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          report("unexpected result beat, status", out_item_i.status, 0);
        end else begin
          want = due_results.pop_front();
          n_checked++;
          if (out_item_i.status !== want.status)
            report("status", out_item_i.status, want.status);
          if (out_item_i.path_length !== want.path_length)
            report("path_length", out_item_i.path_length, want.path_length);
          if (out_item_i.out_row !== want.out_row)
            report("out_row", out_item_i.out_row, want.out_row);
          if (out_item_i.out_col !== want.out_col)
            report("out_col", out_item_i.out_col, want.out_col);
          if (out_item_i.is_last !== want.is_last)
            report("is_last", out_item_i.is_last, want.is_last);
        end
      end
    end
    pending_o  <= due_results.size();
    fail_cnt_o <= n_fail;
    checked_o  <= n_checked;
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import mdfs_pkg::*;

  localparam int unsigned MAX_ROWS = 64;
  localparam int unsigned MAX_COLS = 64;
  localparam int unsigned RANDOM_BEATS = 1000;
  localparam int unsigned CYCLE_LIMIT = 20_000_000;
  localparam int unsigned TAIL_CYCLES = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned pending, fails, checked;
  int unsigned cycles = 0;
  int unsigned idle_pct = 0, stall_pct = 0;
  int unsigned beats = 0, phases = 0, solves = 0, big_left = 3;
  int nr = 8, nc = 8, sr = 1, sc = 1, gr = 8, gc = 8;

  maze_dfs_path_finder #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  maze_dfs_checker #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) chk (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_item_i  (in_item),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_item_i (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .fail_cnt_o (fails),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int clip(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned pick_coord(int n);
    int unsigned k;
    k = $urandom_range(99);
    if (k < 85) return $urandom_range(1, n);
    if (k < 90) return 0;
    if (k < 95) return 127;
    return n + 1;
  endfunction

  task automatic send(op_e op, int unsigned r, int unsigned c, int unsigned idx);
    in_item_t it;
    it.op = op;
    it.cell_row = 7'(r);
    it.cell_col = 7'(c);
    it.path_index = 12'(idx);
    in_item <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats++;
    if (op == OP_SOLVE) solves++;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_index <= idx;
    cfg_data <= 7'(val);
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_maze(int unsigned rows, int unsigned cols, int unsigned srow,
                          int unsigned scol, int unsigned grow, int unsigned gcol);
    drain();
    cfg_write(CFG_MAZE_ROWS, rows);
    cfg_write(CFG_MAZE_COLS, cols);
    cfg_write(CFG_START_ROW, srow);
    cfg_write(CFG_START_COL, scol);
    cfg_write(CFG_GOAL_ROW, grow);
    cfg_write(CFG_GOAL_COL, gcol);
    cfg_valid <= 1'b0;
    nr = clip(rows % 128, MAX_ROWS);
    nc = clip(cols % 128, MAX_COLS);
    sr = clip(srow % 128, nr);
    sc = clip(scol % 128, nc);
    gr = clip(grow % 128, nr);
    gc = clip(gcol % 128, nc);
  endtask

  initial begin
    int unsigned k, rows, cols, phase_end, blk_max;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset setup is 8x8, start top left, goal bottom right
    send(OP_READ, 0, 0, 0);
    send(OP_SOLVE, 127, 127, 4095);
    send(OP_READ, 0, 0, 0);
    send(OP_READ, 0, 0, 14);
    send(OP_READ, 127, 127, 4095);
    send(OP_BLOCK, 1, 1, 0);
    send(OP_BLOCK, 8, 8, 0);
    send(OP_BLOCK, 0, 0, 0);
    send(OP_BLOCK, 127, 127, 4095);
    send(OP_BLOCK, 4, 9, 0);
    send(OP_BLOCK, 1, 2, 0);
    send(OP_READ, 0, 0, 1);
    send(OP_BLOCK, 2, 1, 0);
    send(OP_SOLVE, 0, 0, 0);
    send(OP_READ, 0, 0, 0);
    send(OP_CLEAR, 0, 0, 0);
    send(OP_BLOCK, 3, 3, 0);
    send(OP_SOLVE, 0, 0, 0);
    // goal on a wall, then start on a wall, then both on the same walled cell
    set_maze(8, 8, 1, 1, 3, 3);
    send(OP_SOLVE, 0, 0, 0);
    send(OP_READ, 0, 0, 4);
    set_maze(8, 8, 3, 3, 8, 8);
    send(OP_SOLVE, 0, 0, 0);
    set_maze(8, 8, 3, 3, 3, 3);
    send(OP_SOLVE, 0, 0, 0);
    send(OP_READ, 0, 0, 0);
    drain();
    cfg_write(CFG_SPARE, 127);
    cfg_valid <= 1'b0;
    send(OP_SOLVE, 0, 0, 0);
    // saturating sizes and coordinates: 64 rows, 1 column
    set_maze(127, 0, 0, 127, 127, 0);
    send(OP_SOLVE, 0, 0, 0);
    send(OP_READ, 0, 0, 63);

    phase_end = beats + RANDOM_BEATS;
    while (beats < phase_end) begin
      phases++;
      k = $urandom_range(19);
      if ((k == 0 || phases == 3) && big_left != 0) begin
        rows = MAX_ROWS;
        cols = MAX_COLS;
        big_left--;
      end else if (k == 1) begin
        rows = 1;
        cols = $urandom_range(1, MAX_COLS);
      end else if (k == 2) begin
        rows = $urandom_range(1, MAX_ROWS);
        cols = 1;
      end else if (k == 3) begin
        rows = $urandom_range(1) ? 0 : $urandom_range(65, 127);
        cols = $urandom_range(0, 9);
      end else begin
        rows = $urandom_range(1, 10);
        cols = $urandom_range(1, 10);
      end
      nr = clip(rows, MAX_ROWS);
      nc = clip(cols, MAX_COLS);
      set_maze(rows, cols, pick_coord(nr), pick_coord(nc), pick_coord(nr), pick_coord(nc));
      case (phases % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      blk_max = (nr * nc / 3 < 12) ? nr * nc / 3 : 12;

      k = beats + $urandom_range(15, 40);
      while (beats < k) begin
        if ($urandom_range(99) < 8)
          send(OP_CLEAR, $urandom_range(127), $urandom_range(127), $urandom_range(4095));
        repeat ($urandom_range(0, blk_max)) begin
          case ($urandom_range(99)) inside
            [0:74]:  send(OP_BLOCK, $urandom_range(1, nr), $urandom_range(1, nc),
                          $urandom_range(4095));
            [75:82]: send(OP_BLOCK, sr, sc, $urandom_range(4095));
            [83:89]: send(OP_BLOCK, gr, gc, $urandom_range(4095));
            default: send(OP_BLOCK, $urandom_range(127), $urandom_range(127),
                          $urandom_range(4095));
          endcase
        end
        send(OP_SOLVE, $urandom_range(127), $urandom_range(127), $urandom_range(4095));
        if ($urandom_range(99) < 15) drain();
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(99)) inside
            [0:59]:  send(OP_READ, $urandom_range(127), $urandom_range(127),
                          $urandom_range(0, nr + nc));
            [60:84]: send(OP_READ, $urandom_range(127), $urandom_range(127),
                          $urandom_range(0, nr * nc));
            [85:94]: send(OP_READ, $urandom_range(127), $urandom_range(127),
                          $urandom_range(4095));
            default: send(op_e'($urandom_range(3)), $urandom_range(127),
                          $urandom_range(127), $urandom_range(4095));
          endcase
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d input beats in %0d setups after the directed part, %0d solves,",
             beats, phases, solves);
    $display("%0d results compared; grids 1x1 to %0dx%0d under mixed sender gaps and stalls.",
             checked, MAX_ROWS, MAX_COLS);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
